// File: sv/jse_pkg.sv
// Package: shared types, character constants and helpers for the JSON string escaper.
package jse_pkg;

    // Output byte counter width
    localparam int COUNT_WIDTH = 16;
    // Width of the capacity register
    localparam int CAP_WIDTH = 16;
    // Width used for the fit compare, wide enough for count + 1 and the capacity
    localparam int CMP_WIDTH = (COUNT_WIDTH + 1 > CAP_WIDTH) ? COUNT_WIDTH + 1 : CAP_WIDTH + 1;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = '1;

    // Escape index width: covers the longest sequence of six bytes
    localparam int IDX_WIDTH = 3;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // How a source byte is rendered
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,   // nothing to emit
        KIND_PLAIN   = 2'd1,   // byte passes through
        KIND_SHORT   = 2'd2,   // backslash plus one letter
        KIND_UNICODE = 2'd3    // backslash u 0 0 hex hex
    } esc_kind_t;

    // One queue entry between front and back
    typedef struct packed {
        esc_kind_t  kind;
        logic [7:0] data;   // plain byte, short escape letter, or control byte
        logic       term;   // emit the terminator after the bytes
    } esc_op_t;

    // Short escape letter for a byte, or NUL when it has none
    function automatic logic [7:0] short_escape(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            CH_QUOTE:  e = CH_QUOTE;
            CH_BSLASH: e = CH_BSLASH;
            CH_SLASH:  e = CH_SLASH;
            CH_BS:     e = CH_LOW_B;
            CH_FF:     e = CH_LOW_F;
            CH_LF:     e = CH_LOW_N;
            CH_CR:     e = CH_LOW_R;
            CH_TAB:    e = CH_LOW_T;
            default:   e = CH_NUL;
        endcase
        return e;
    endfunction

    // Lower-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        case (n)
            4'h0: d = 8'h30;
            4'h1: d = 8'h31;
            4'h2: d = 8'h32;
            4'h3: d = 8'h33;
            4'h4: d = 8'h34;
            4'h5: d = 8'h35;
            4'h6: d = 8'h36;
            4'h7: d = 8'h37;
            4'h8: d = 8'h38;
            4'h9: d = 8'h39;
            4'hA: d = 8'h61;
            4'hB: d = 8'h62;
            4'hC: d = 8'h63;
            4'hD: d = 8'h64;
            4'hE: d = 8'h65;
            default: d = 8'h66;
        endcase
        return d;
    endfunction

    // Number of bytes in the rendering of one entry
    function automatic logic [IDX_WIDTH-1:0] kind_len(input esc_kind_t k);
        logic [IDX_WIDTH-1:0] n;
        case (k)
            KIND_PLAIN:   n = IDX_WIDTH'(1);
            KIND_SHORT:   n = IDX_WIDTH'(2);
            KIND_UNICODE: n = IDX_WIDTH'(6);
            default:      n = '0;
        endcase
        return n;
    endfunction

    // Byte number cnt fits when cnt + 1 < capacity and the counter is not saturated
    function automatic logic byte_fits(input logic [COUNT_WIDTH-1:0] cnt,
                                       input logic [CAP_WIDTH-1:0] cap);
        logic [CMP_WIDTH-1:0] nxt;
        logic [CMP_WIDTH-1:0] lim;
        nxt = CMP_WIDTH'(cnt) + CMP_WIDTH'(1);
        lim = CMP_WIDTH'(cap);
        return (nxt < lim) && (cnt != {COUNT_WIDTH{1'b1}});
    endfunction

endpackage

// File: sv/jse_item_if.sv
// Interface: source byte channel with valid/ready handshake.
interface jse_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       has_byte;
    logic       source_end;

    modport source (output valid, output src_byte, output has_byte, output source_end,
                    input ready);
    modport sink   (input valid, input src_byte, input has_byte, input source_end,
                    output ready);
endinterface

// File: sv/jse_result_if.sv
// Interface: escaped result channel with valid/ready handshake.
interface jse_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       status;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    input status, output ready);
endinterface

// File: sv/json_string_escaper.sv
// The first word caused by an input word passes through a queue slot, the entry register and the output register.
// Throughput: one result word per cycle from the single output register while the result side is ready; a plain
// byte gives one word, a short escape two, a \u00XX escape six, and the terminator one more.
// Input is taken whenever the two-entry queue has room, including while a result is stalled.
// Reset (rst_n, asynchronous, active low) clears counter, flags and queue; capacity returns to 65535.
module json_string_escaper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jse_pkg::CAP_WIDTH-1:0] cfg_wdata,
    jse_item_if.sink                      item,
    jse_result_if.source                  result
);
    import jse_pkg::*;

    logic [CAP_WIDTH-1:0] capacity_reg;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    esc_op_t              push_op;
    esc_op_t              head_op;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    jse_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (push_op)
    );

    jse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (push_op),
        .pop       (q_pop),
        .head_op   (head_op),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .head_op     (head_op),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .result      (result)
    );

`ifndef SYNTHESIS
    // Terminator always closes the run of its input word
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.string_end |-> result.run_last)
        else $error("terminator without run_last");

    // Status only on the terminator, and the terminator carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.string_end |-> !result.status)
        else $error("status set on a byte word");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.string_end |-> result.out_byte == CH_NUL)
        else $error("terminator byte not zero");

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: sv/jse_front.sv
// Front end: accepts source words, tracks the NUL state and classifies each byte.
module jse_front (
    input  logic            clk,
    input  logic            rst_n,
    jse_item_if.sink        item,
    input  logic            q_full,
    output logic            q_push,
    output jse_pkg::esc_op_t q_op
);
    import jse_pkg::*;

    logic       string_done_reg;
    logic       string_done_next;
    logic       accept;
    logic [7:0] esc;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign esc        = short_escape(item.src_byte);

    // Classify the incoming byte
    always_comb
    begin
        q_op.term = item.source_end;
        q_op.data = item.src_byte;
        q_op.kind = KIND_PLAIN;
        if (!item.has_byte || string_done_reg || item.src_byte == CH_NUL)
        begin
            q_op.kind = KIND_NONE;
        end
        else if (esc != CH_NUL)
        begin
            q_op.kind = KIND_SHORT;
            q_op.data = esc;
        end
        else if (item.src_byte < CTRL_LIMIT)
        begin
            q_op.kind = KIND_UNICODE;
        end
    end

    // Words that produce nothing are taken but not queued
    assign q_push = accept && (q_op.kind != KIND_NONE || item.source_end);

    // NUL ends the logical string until the end word
    always_comb
    begin
        string_done_next = string_done_reg;
        if (accept)
        begin
            if (item.source_end)
            begin
                string_done_next = 1'b0;
            end
            else if (item.has_byte && item.src_byte == CH_NUL)
            begin
                string_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_done_reg <= 1'b0;
        end
        else
        begin
            string_done_reg <= string_done_next;
        end
    end

endmodule

// File: sv/jse_queue.sv
// Two-entry queue between the classifier and the emitter.
module jse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jse_pkg::esc_op_t push_op,
    input  logic             pop,
    output jse_pkg::esc_op_t head_op,
    output logic             full,
    output logic             not_empty
);
    import jse_pkg::*;

    esc_op_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: sv/jse_back.sv
// Back end: expands queued entries into output words, counts against capacity.
module jse_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [jse_pkg::CAP_WIDTH-1:0] capacity,
    input  jse_pkg::esc_op_t              head_op,
    input  logic                          q_not_empty,
    output logic                          q_pop,
    jse_result_if.source                  result
);
    import jse_pkg::*;

    esc_op_t                op_reg;
    logic                   op_valid_reg;
    logic                   op_valid_next;
    logic [IDX_WIDTH-1:0]   idx_reg;
    logic [IDX_WIDTH-1:0]   idx_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic [7:0]             out_byte_next;
    logic                   run_last_reg;
    logic                   run_last_next;
    logic                   string_end_reg;
    logic                   string_end_next;
    logic                   status_reg;
    logic                   status_next;

    logic [IDX_WIDTH-1:0]   len;
    logic [IDX_WIDTH-1:0]   idx_inc;
    logic                   bytes_left;
    logic                   step;
    logic                   byte_go;
    logic                   more;
    logic                   done;
    logic [7:0]             cur_byte;

    assign len        = kind_len(op_reg.kind);
    assign idx_inc    = idx_reg + IDX_WIDTH'(1);
    assign count_inc  = count_reg + COUNT_WIDTH'(1);
    assign bytes_left = (idx_reg < len);
    assign step       = op_valid_reg && (!out_valid_reg || result.ready);
    assign byte_go    = bytes_left && !ovf_reg && byte_fits(count_reg, capacity);
    assign more       = (idx_inc < len) && byte_fits(count_inc, capacity);

    // Byte at the current position of the escape sequence
    always_comb
    begin
        cur_byte = op_reg.data;
        case (op_reg.kind)
            KIND_SHORT:
            begin
                if (idx_reg == '0)
                begin
                    cur_byte = CH_BSLASH;
                end
            end
            KIND_UNICODE:
            begin
                case (idx_reg)
                    IDX_WIDTH'(0): cur_byte = CH_BSLASH;
                    IDX_WIDTH'(1): cur_byte = CH_LOW_U;
                    IDX_WIDTH'(2): cur_byte = CH_ZERO;
                    IDX_WIDTH'(3): cur_byte = CH_ZERO;
                    IDX_WIDTH'(4): cur_byte = hex_digit(op_reg.data[7:4]);
                    default:       cur_byte = hex_digit(op_reg.data[3:0] & NIBBLE_MASK);
                endcase
            end
            default:
            begin
                cur_byte = op_reg.data;
            end
        endcase
    end

    // One step of the emitter
    always_comb
    begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        done            = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        string_end_next = string_end_reg;
        status_next     = status_reg;
        if (step)
        begin
            if (byte_go)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = cur_byte;
                run_last_next   = !more && !op_reg.term;
                string_end_next = 1'b0;
                status_next     = 1'b0;
                count_next      = count_inc;
                idx_next        = idx_inc;
                // Sequence cut short by the capacity
                if (!more && (idx_inc < len))
                begin
                    ovf_next = 1'b1;
                end
                done = !more && !op_reg.term;
            end
            else
            begin
                done = 1'b1;
                if (op_reg.term)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = CH_NUL;
                    run_last_next   = 1'b1;
                    string_end_next = 1'b1;
                    status_next     = ovf_reg || bytes_left || (capacity == '0);
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
                else if (bytes_left)
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    // Load the next entry as soon as the current one finishes
    assign q_pop = q_not_empty && (!op_valid_reg || (step && done));

    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (step && done)
        begin
            op_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            op_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            idx_reg       <= q_pop ? '0 : idx_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= head_op;
        end
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        string_end_reg <= string_end_next;
        status_reg     <= status_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.run_last   = run_last_reg;
    assign result.string_end = string_end_reg;
    assign result.status     = status_reg;

endmodule

// File: tb/jse_escape_checker.sv
// Checker: predicts the escaped words for each accepted source word and compares them.
module jse_escape_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jse_pkg::CAP_WIDTH-1:0] cfg_wdata,
    jse_item_if                           item_mon,
    jse_result_if                         result_mon,
    output int                            mismatches,
    output int                            words_owed
);
    import jse_pkg::*;

    localparam logic [7:0] LOWER_A = 8'h61;

    // One expected word on the result channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       term;
        logic       ovf;
    } escaped_word_t;

    escaped_word_t          escaped_q[$];
    logic [CAP_WIDTH-1:0]   capacity   = CAP_RESET;
    logic [COUNT_WIDTH-1:0] emitted    = '0;
    logic                   overflowed = 1'b0;
    logic                   nul_seen   = 1'b0;

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return LOWER_A + 8'(n) - 8'd10;
    endfunction

    // Expected words caused by one source word
    task automatic escape_source_word(input logic [7:0] c, input logic has, input logic fin);
        logic [7:0] seq [6];
        logic [7:0] letter;
        int         len;
        int         first;
        first = escaped_q.size();
        if (has && !nul_seen && !overflowed)
        begin
            if (c == CH_NUL)
                nul_seen = 1'b1;
            else
            begin
                case (c)
                    CH_QUOTE:  letter = CH_QUOTE;
                    CH_BSLASH: letter = CH_BSLASH;
                    CH_SLASH:  letter = CH_SLASH;
                    CH_BS:     letter = CH_LOW_B;
                    CH_FF:     letter = CH_LOW_F;
                    CH_LF:     letter = CH_LOW_N;
                    CH_CR:     letter = CH_LOW_R;
                    CH_TAB:    letter = CH_LOW_T;
                    default:   letter = CH_NUL;
                endcase
                if (letter != CH_NUL)
                begin
                    seq[0] = CH_BSLASH;
                    seq[1] = letter;
                    len = 2;
                end
                else if (c < CTRL_LIMIT)
                begin
                    seq[0] = CH_BSLASH;
                    seq[1] = CH_LOW_U;
                    seq[2] = CH_ZERO;
                    seq[3] = CH_ZERO;
                    seq[4] = hex_char(c[7:4]);
                    seq[5] = hex_char(c[3:0]);
                    len = 6;
                end
                else
                begin
                    seq[0] = c;
                    len = 1;
                end
                // bytes that still fit go out, the first that does not sets the flag
                for (int i = 0; i < len; i++)
                begin
                    if (int'(emitted) + 1 >= int'(capacity) || emitted == '1)
                    begin
                        overflowed = 1'b1;
                        break;
                    end
                    escaped_q.push_back('{data: seq[i], last: 1'b0, term: 1'b0, ovf: 1'b0});
                    emitted = emitted + 1'b1;
                end
            end
        end
        // terminator, then a fresh string
        if (fin)
        begin
            escaped_q.push_back('{data: CH_NUL, last: 1'b0, term: 1'b1,
                                  ovf: overflowed || capacity == '0});
            emitted    = '0;
            overflowed = 1'b0;
            nul_seen   = 1'b0;
        end
        if (escaped_q.size() > first)
            escaped_q[escaped_q.size() - 1].last = 1'b1;
    endtask

    task automatic report(input string what, input escaped_word_t want,
                          input escaped_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t escaper %s: expected byte %h last %b end %b status %b, got byte %h last %b end %b status %b",
                     $time, what, want.data, want.last, want.term, want.ovf,
                     got.data, got.last, got.term, got.ovf);
    endtask

    // Oldest expectation against the word just taken
    task automatic compare_escaped_word(input escaped_word_t got);
        escaped_word_t want;
        if (escaped_q.size() == 0)
        begin
            report("word with nothing expected", '0, got);
            return;
        end
        want = escaped_q.pop_front();
        if (got.data !== want.data || got.last !== want.last ||
            got.term !== want.term || got.ovf !== want.ovf)
            report("word mismatch", want, got);
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity   = CAP_RESET;
            emitted    = '0;
            overflowed = 1'b0;
            nul_seen   = 1'b0;
            escaped_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (item_mon.valid && item_mon.ready)
                escape_source_word(item_mon.src_byte, item_mon.has_byte, item_mon.source_end);
            if (result_mon.valid && result_mon.ready)
                compare_escaped_word('{data: result_mon.out_byte, last: result_mon.run_last,
                                       term: result_mon.string_end, ovf: result_mon.status});
        end
        words_owed = escaped_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives source strings and capacity settings into the escaper and gives the verdict.
module tb_top;
    import jse_pkg::*;

    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_WAIT     = 14;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_wdata = '0;

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_request  = 1'b0;
    int source_words  = 0;
    int mismatches;
    int words_owed;

    jse_item_if   src_ch ();
    jse_result_if esc_ch ();

    json_string_escaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (src_ch),
        .result    (esc_ch)
    );

    jse_escape_checker esc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_mon   (src_ch),
        .result_mon (esc_ch),
        .mismatches (mismatches),
        .words_owed (words_owed)
    );

    always #5 clk = ~clk;

    // Hard stop
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Bytes that take a short escape
    function automatic logic [7:0] escapable(input int i);
        case (i)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_BS;
            4:       return CH_FF;
            5:       return CH_LF;
            6:       return CH_CR;
            default: return CH_TAB;
        endcase
    endfunction

    // Mix of plain text, escapes, control bytes, high bytes and the odd NUL
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(8'h20, 8'h7E));
            3:       return escapable($urandom_range(0, 7));
            4:       return 8'($urandom_range(1, 8'h1F));
            5:       return 8'($urandom_range(8'h80, 8'hFF));
            6:       return ($urandom_range(0, 4) == 0) ? CH_NUL : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    // One source word; valid stays high afterwards unless the next call idles first
    task automatic send_word(input logic [7:0] b, input logic hb, input logic fin);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            src_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_ch.valid      = 1'b1;
        src_ch.src_byte   = b;
        src_ch.has_byte   = hb;
        src_ch.source_end = fin;
        do
            @(posedge clk);
        while (!src_ch.ready);
        @(negedge clk);
        if (hb || fin)
            source_words++;
    endtask

    // Only while idle: after the last result, ignored words may still be in flight
    task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
        src_ch.valid = 1'b0;
        while (words_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // A whole string of len bytes, closed by an end word or by end on its last byte
    task automatic send_string(input int len);
        bit joined;
        joined = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(pick_byte(), 1'b1, joined && (k == len - 1));
        end
        if (!joined)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Random strings, new capacity and idling mode for each
    task automatic run_strings(input int target, input int cap_lo, input int cap_hi,
                               input int max_len);
        int goal;
        goal = source_words + target;
        while (source_words < goal)
        begin
            write_capacity(CAP_WIDTH'($urandom_range(cap_lo, cap_hi)));
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            send_string($urandom_range(0, max_len));
        end
    endtask

    // Result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        esc_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                esc_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            esc_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!esc_ch.valid);
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        src_ch.valid      = 1'b0;
        src_ch.src_byte   = '0;
        src_ch.has_byte   = 1'b0;
        src_ch.source_end = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every byte class at the reset capacity
        send_word(8'h41, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_word(escapable(i), 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h1F, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        // byte and end together, longest run of words
        send_word(8'h1E, 1'b1, 1'b1);
        // neither byte nor end
        send_word(8'hA5, 1'b0, 1'b0);
        // NUL cuts the string, later bytes ignored
        send_word(8'h41, 1'b1, 1'b0);
        send_word(CH_NUL, 1'b1, 1'b0);
        send_word(CH_QUOTE, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        // empty string
        send_word(8'hFF, 1'b0, 1'b1);

        // capacity of one: only the terminator fits
        write_capacity(CAP_WIDTH'(1));
        send_word(8'h41, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);

        // escape cut short by overflow, then bytes after overflow
        write_capacity(CAP_WIDTH'(4));
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h42, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // exact fit, then one byte too many
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'h64, 1'b1, 1'b1);

        // small capacities, overflow common
        run_strings(14, 1, 24, 10);

        // back-pressure: result side holds off while the source keeps offering
        write_capacity('1);
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        hold_request  = 1'b1;
        send_string(16);

        run_strings(20, 1, 40, 14);
        run_strings(10, 65535, 65535, 16);

        // drain
        src_ch.valid = 1'b0;
        while (words_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
